>>> sv/rrld_pkg.sv
package rrld_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [15:0] IMAGE_WIDTH_RESET  = 16'd64;
  localparam logic [15:0] IMAGE_HEIGHT_RESET = 16'd64;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [7:0]  LEN8_ESCAPE  = 8'hff;
  localparam logic [15:0] LEN16_ESCAPE = 16'hffff;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef enum logic [3:0] {
    PH_BLUE     = 4'd0,
    PH_GREEN    = 4'd1,
    PH_RED      = 4'd2,
    PH_LEN8     = 4'd3,
    PH_LEN16_LO = 4'd4,
    PH_LEN16_HI = 4'd5,
    PH_LEN32_0  = 4'd6,
    PH_LEN32_1  = 4'd7,
    PH_LEN32_2  = 4'd8,
    PH_LEN32_3  = 4'd9
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [31:0] start_index;
    logic [31:0] run_count;
    logic        final_result;
  } out_t;

  // Results produced by one decoded byte, zero to two of them.
  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } push_t;

endpackage

>>> sv/rrld_core.sv
module rrld_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [rrld_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rrld_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               byte_valid,
  output logic                               byte_stall,
  input  rrld_pkg::in_t                      byte_item,
  input  logic                               room,
  output rrld_pkg::push_t                    push
);
  import rrld_pkg::*;

  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [31:0] total;

  logic        pend;
  in_t         pend_item;
  logic        advance;

  phase_t      phase, phase_next;
  logic [7:0]  held_blue, held_blue_next;
  logic [7:0]  held_green, held_green_next;
  logic [7:0]  held_red, held_red_next;
  logic [31:0] acc, acc_next;
  logic [31:0] filled, filled_next;
  logic        err, err_next;

  logic        do_check;
  logic [31:0] run_len;
  logic [15:0] acc16;
  logic [32:0] end_index;
  logic        has_a, has_b;
  out_t        res_a, res_b;

  assign advance    = pend && room;
  assign byte_stall = pend && !room;

  // Pixel count of the bitmap; follows a register write at once.
  assign total = {16'b0, image_width} * {16'b0, image_height};

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
    end else begin
      if (cfg_wr_en && cfg_index == REG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end
      if (cfg_wr_en && cfg_index == REG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (!byte_stall) begin
      pend <= byte_valid;
    end
    if (byte_valid && !byte_stall) begin
      pend_item <= byte_item;
    end
  end

  always_comb begin
    phase_next      = phase;
    held_blue_next  = held_blue;
    held_green_next = held_green;
    held_red_next   = held_red;
    acc_next        = acc;
    filled_next     = filled;
    err_next        = err;
    do_check        = 1'b0;
    run_len         = '0;
    acc16           = {pend_item.byte_value, acc[7:0]};
    has_a           = 1'b0;
    has_b           = 1'b0;
    res_a           = '0;
    res_b           = '0;

    if (!err) begin
      case (phase)
        PH_BLUE: begin
          held_blue_next = pend_item.byte_value;
          phase_next     = PH_GREEN;
        end
        PH_GREEN: begin
          held_green_next = pend_item.byte_value;
          phase_next      = PH_RED;
        end
        PH_RED: begin
          held_red_next = pend_item.byte_value;
          phase_next    = PH_LEN8;
        end
        PH_LEN8: begin
          if (pend_item.byte_value != LEN8_ESCAPE) begin
            do_check = 1'b1;
            run_len  = {24'b0, pend_item.byte_value};
          end else begin
            acc_next   = '0;
            phase_next = PH_LEN16_LO;
          end
        end
        PH_LEN16_LO: begin
          acc_next   = {24'b0, pend_item.byte_value};
          phase_next = PH_LEN16_HI;
        end
        PH_LEN16_HI: begin
          if (acc16 == LEN16_ESCAPE) begin
            acc_next   = '0;
            phase_next = PH_LEN32_0;
          end else begin
            acc_next = {16'b0, acc16};
            do_check = 1'b1;
            run_len  = {16'b0, acc16};
          end
        end
        PH_LEN32_0: begin
          acc_next   = acc | {24'b0, pend_item.byte_value};
          phase_next = PH_LEN32_1;
        end
        PH_LEN32_1: begin
          acc_next   = acc | {16'b0, pend_item.byte_value, 8'b0};
          phase_next = PH_LEN32_2;
        end
        PH_LEN32_2: begin
          acc_next   = acc | {8'b0, pend_item.byte_value, 16'b0};
          phase_next = PH_LEN32_3;
        end
        PH_LEN32_3: begin
          acc_next = acc | {pend_item.byte_value, 24'b0};
          do_check = 1'b1;
          run_len  = acc | {pend_item.byte_value, 24'b0};
        end
        default: begin
          phase_next = PH_BLUE;
        end
      endcase
    end

    end_index = {1'b0, filled} + {1'b0, run_len};

    if (do_check) begin
      has_a = 1'b1;
      res_a.start_index = filled;
      if (run_len == '0 || end_index > {1'b0, total}) begin
        err_next     = 1'b1;
        res_a.status = ST_ERR;
      end else begin
        res_a.status    = ST_RUN;
        res_a.blue      = held_blue;
        res_a.green     = held_green;
        res_a.red       = held_red;
        res_a.run_count = run_len;
        filled_next     = end_index[31:0];
        phase_next      = PH_BLUE;
        acc_next        = '0;
      end
    end

    if (pend_item.last_byte) begin
      if (!err_next) begin
        has_b             = 1'b1;
        res_b.status      = (phase_next == PH_BLUE) ? ST_DONE : ST_ERR;
        res_b.start_index = filled_next;
      end
      // Start over for the next bitmap.
      phase_next  = PH_BLUE;
      acc_next    = '0;
      filled_next = '0;
      err_next    = 1'b0;
    end

    res_a.final_result = !has_b;
    res_b.final_result = 1'b1;

    push.first  = has_a ? res_a : res_b;
    push.second = res_b;
    if (!advance) begin
      push.count = 2'd0;
    end else begin
      push.count = {1'b0, has_a} + {1'b0, has_b};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_BLUE;
      acc    <= '0;
      filled <= '0;
      err    <= 1'b0;
    end else if (advance) begin
      phase  <= phase_next;
      acc    <= acc_next;
      filled <= filled_next;
      err    <= err_next;
    end
    if (advance) begin
      held_blue  <= held_blue_next;
      held_green <= held_green_next;
      held_red   <= held_red_next;
    end
  end

endmodule

>>> sv/rrld_out_fifo.sv
module rrld_out_fifo (
  input  logic            clk,
  input  logic            rst,
  input  rrld_pkg::push_t push,
  output logic            room,
  output logic            result_valid,
  input  logic            result_stall,
  output rrld_pkg::out_t  result_item
);
  import rrld_pkg::*;

  out_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_AW:0]   count;
  logic               pop;

  assign result_valid = (count != '0);
  assign result_item  = mem[rptr];
  assign pop          = result_valid && !result_stall;
  // Keep space for the two results one byte can cause.
  assign room         = (count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + FIFO_AW'(push.count);
      rptr  <= rptr + FIFO_AW'(pop);
      count <= count + (FIFO_AW + 1)'(push.count) - (FIFO_AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wptr + FIFO_AW'(1)] <= push.second;
    end
  end

endmodule

>>> sv/residual_run_length_decoder.sv
// Residual run-length decoder: one stream byte per transfer, run descriptors out.
// Flow: each byte is held in a pending register until the result queue has room;
// there it is decoded and its results go to the result queue. Rate: one byte per cycle
// unless input stalls; a byte with two results gives two output transfers, and input
// stalls only while a byte waits and the result queue holds three or more.
// Reset: synchronous rst returns to the blue-byte phase, 64 by 64, empty result queue.
module residual_run_length_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [rrld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrld_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            byte_valid,
  output logic                            byte_stall,
  input  rrld_pkg::in_t                   byte_item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output rrld_pkg::out_t                  result_item
);
  import rrld_pkg::*;

  push_t push;
  logic  room;

  rrld_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .room       (room),
    .push       (push)
  );

  rrld_out_fifo u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

>>> tb/sv/residual_run_length_decoder_test.sv
module residual_run_length_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rrld_pkg::*;

  localparam int BYTES_PER_PHASE = 184;
  localparam int PHASES          = 9;
  localparam int STALL_LIMIT     = 2000;
  localparam int DIRECTED_ROWS   = 27;

  typedef struct packed {
    logic [7:0]  value;
    logic        last_byte;
    logic        pinned;
    logic [1:0]  status;
    logic [31:0] start_index;
  } directed_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  byte_valid = 1'b0;
  logic                  byte_stall;
  in_t                   byte_item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  out_t                  result_item;

  // Predictor state
  logic [15:0] width_reg;
  logic [15:0] height_reg;
  phase_t      phase;
  logic [7:0]  blue_held;
  logic [7:0]  green_held;
  logic [7:0]  red_held;
  logic [31:0] length_acc;
  logic [31:0] filled;
  logic        err_seen;

  out_t pending_results[$];
  directed_row_t directed_rows [DIRECTED_ROWS];

  int tx_idle_pct = 17;
  int rx_idle_pct = 61;
  int bytes_sent = 0;
  int mismatches = 0;
  int runs_checked = 0;
  int done_checked = 0;
  int err_checked = 0;
  int quiet_cycles = 0;

  residual_run_length_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  always #4 clk = ~clk;

  function automatic void clear_bitmap();
    phase = PH_BLUE;
    blue_held = '0;
    green_held = '0;
    red_held = '0;
    length_acc = '0;
    filled = '0;
    err_seen = 1'b0;
  endfunction

  function automatic logic [31:0] room_left();
    logic [31:0] total;
    total = {16'd0, width_reg} * {16'd0, height_reg};
    return (filled >= total) ? 32'd0 : total - filled;
  endfunction

  function automatic out_t status_result(input logic [1:0] status);
    out_t r;
    r = '0;
    r.status = status;
    r.start_index = filled;
    return r;
  endfunction

  // Check a complete length against the room left; emit a descriptor or an error.
  function automatic out_t close_run(input logic [31:0] run);
    out_t r;
    if (run == 32'd0 || run > room_left()) begin
      err_seen = 1'b1;
      return status_result(ST_ERR);
    end
    r = '0;
    r.status = ST_RUN;
    r.blue = blue_held;
    r.green = green_held;
    r.red = red_held;
    r.start_index = filled;
    r.run_count = run;
    filled = filled + run;
    phase = PH_BLUE;
    length_acc = '0;
    return r;
  endfunction

  task automatic decode_byte(input in_t item);
    out_t        made[$];
    out_t        tail;
    logic [31:0] wide;
    wide = {24'd0, item.byte_value};
    if (err_seen) begin
      // swallow until the end of the bitmap
      if (item.last_byte) clear_bitmap();
    end else begin
      case (phase)
        PH_BLUE: begin
          blue_held = item.byte_value;
          phase = PH_GREEN;
        end
        PH_GREEN: begin
          green_held = item.byte_value;
          phase = PH_RED;
        end
        PH_RED: begin
          red_held = item.byte_value;
          phase = PH_LEN8;
        end
        PH_LEN8: begin
          if (item.byte_value != LEN8_ESCAPE) begin
            made.push_back(close_run(wide));
          end else begin
            length_acc = '0;
            phase = PH_LEN16_LO;
          end
        end
        PH_LEN16_LO: begin
          length_acc = wide;
          phase = PH_LEN16_HI;
        end
        PH_LEN16_HI: begin
          length_acc = length_acc | (wide << 8);
          if (length_acc == {16'd0, LEN16_ESCAPE}) begin
            length_acc = '0;
            phase = PH_LEN32_0;
          end else begin
            made.push_back(close_run(length_acc));
          end
        end
        PH_LEN32_0, PH_LEN32_1, PH_LEN32_2, PH_LEN32_3: begin
          length_acc = length_acc | (wide << (8 * (phase - PH_LEN32_0)));
          if (phase == PH_LEN32_3) made.push_back(close_run(length_acc));
          else phase = phase_t'(phase + 1);
        end
        default: phase = PH_BLUE;
      endcase
      if (item.last_byte) begin
        if (!err_seen) made.push_back(status_result(phase == PH_BLUE ? ST_DONE : ST_ERR));
        clear_bitmap();
      end
      if (made.size() > 0) begin
        tail = made.pop_back();
        tail.final_result = 1'b1;
        made.push_back(tail);
      end
      foreach (made[i]) pending_results.push_back(made[i]);
    end
  endtask

  task automatic report_mismatch(input string msg);
    // hold the log to the first hundred
    if (mismatches < 100) $display("tb: mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result, status %0d", got.status));
    end else begin
      want = pending_results.pop_front();
      check_field("status", 32'(got.status), 32'(want.status));
      check_field("blue", 32'(got.blue), 32'(want.blue));
      check_field("green", 32'(got.green), 32'(want.green));
      check_field("red", 32'(got.red), 32'(want.red));
      check_field("start_index", got.start_index, want.start_index);
      check_field("run_count", got.run_count, want.run_count);
      check_field("final_result", 32'(got.final_result), 32'(want.final_result));
      if (want.status == ST_RUN) runs_checked++;
      else if (want.status == ST_DONE) done_checked++;
      else err_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) check_result(result_item);
  end

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if ((byte_valid && byte_stall === 1'b0) || (result_valid === 1'b1 && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_results.size());
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input in_t item, input logic pinned, input logic [1:0] status,
                           input logic [31:0] start_index);
    out_t tail;
    while ($urandom_range(99) < tx_idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= item;
    @(posedge clk);
    while (byte_stall !== 1'b0) @(posedge clk);
    decode_byte(item);
    if (pinned && pending_results.size() > 0) begin
      tail = pending_results.pop_back();
      tail = '0;
      tail.status = status;
      tail.start_index = start_index;
      tail.final_result = 1'b1;
      pending_results.push_back(tail);
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_bitmap();
    logic [7:0]  run_vals[$];
    logic [31:0] len;
    in_t         item;
    int          runs;
    int          cut_run;
    int          stop;
    int          pick;
    if ($urandom_range(99) < 8) begin
      // noise: random bytes, last on the final one
      runs = $urandom_range(1, 12);
      for (int i = 0; i < runs; i++) begin
        item.byte_value = 8'($urandom);
        item.last_byte = (i == runs - 1);
        send_byte(item, 1'b0, ST_RUN, '0);
      end
      return;
    end
    runs = $urandom_range(1, 6);
    cut_run = ($urandom_range(99) < 12) ? $urandom_range(0, runs - 1) : -1;
    for (int r = 0; r < runs; r++) begin
      run_vals.delete();
      pick = $urandom_range(99);
      if (pick < 5) len = 32'd0;
      else if (pick < 12) len = room_left();
      else if (pick < 18) len = room_left() + 32'd1;
      else if (pick < 24) len = $urandom;
      else len = $urandom_range(1, 12);
      run_vals.push_back(8'($urandom));
      run_vals.push_back(8'($urandom));
      run_vals.push_back(8'($urandom));
      pick = $urandom_range(99);
      if (pick < 60) begin
        if (len > 32'd254) len = 32'd254;
        run_vals.push_back(len[7:0]);
      end else if (pick < 85) begin
        if (len > 32'd65534) len = 32'd65534;
        run_vals.push_back(LEN8_ESCAPE);
        run_vals.push_back(len[7:0]);
        run_vals.push_back(len[15:8]);
      end else begin
        run_vals.push_back(LEN8_ESCAPE);
        run_vals.push_back(LEN16_ESCAPE[7:0]);
        run_vals.push_back(LEN16_ESCAPE[15:8]);
        run_vals.push_back(len[7:0]);
        run_vals.push_back(len[15:8]);
        run_vals.push_back(len[23:16]);
        run_vals.push_back(len[31:24]);
      end
      stop = (r == cut_run) ? $urandom_range(0, run_vals.size() - 2) : run_vals.size() - 1;
      for (int i = 0; i <= stop; i++) begin
        item.byte_value = run_vals[i];
        item.last_byte = (i == stop) && (r == cut_run || r == runs - 1);
        send_byte(item, 1'b0, ST_RUN, '0);
      end
      if (r == cut_run) break;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    if (index == REG_IMAGE_WIDTH) width_reg = value;
    else height_reg = value;
    @(negedge clk);
  endtask

  function automatic logic [31:0] size_setting(input int p);
    case (p)
      0: return {16'd64, 16'd64};
      1: return {16'd1, 16'd1};
      2: return {16'd65535, 16'd65535};
      3: return {16'd3, 16'd5};
      4: return {16'd1, 16'd65535};
      5: return {16'd65535, 16'd1};
      6: return {16'd0, 16'd9};
      7: return {16'd200, 16'd150};
      default: return {16'd7, 16'd0};
    endcase
  endfunction

  initial begin
    logic [31:0] dims;
    in_t         item;
    directed_rows = '{
      {8'hFF, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'h00, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'h55, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'hFF, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'h10, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'h00, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'h00, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'hFF, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'h80, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'hFF, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'hFF, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'hFF, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'hFF, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'hFF, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'hFF, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'hFF, 1'b1, 1'b1, ST_ERR, 32'd16},
      {8'h12, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'h34, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'h56, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'h00, 1'b0, 1'b1, ST_ERR, 32'd0},
      {8'h77, 1'b1, 1'b0, ST_RUN, 32'd0},
      {8'h01, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'h02, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'h03, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'h05, 1'b1, 1'b1, ST_DONE, 32'd5},
      {8'h01, 1'b0, 1'b0, ST_RUN, 32'd0},
      {8'h02, 1'b1, 1'b1, ST_ERR, 32'd0}
    };
    width_reg = IMAGE_WIDTH_RESET;
    height_reg = IMAGE_HEIGHT_RESET;
    clear_bitmap();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      item.byte_value = directed_rows[i].value;
      item.last_byte = directed_rows[i].last_byte;
      send_byte(item, directed_rows[i].pinned, directed_rows[i].status,
                directed_rows[i].start_index);
    end

    for (int p = 0; p < PHASES; p++) begin
      // drain before touching the size registers
      byte_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clk);
      repeat (4) @(negedge clk);
      dims = size_setting(p);
      write_reg(REG_IMAGE_WIDTH, dims[31:16]);
      write_reg(REG_IMAGE_HEIGHT, dims[15:0]);
      cfg_wr_en <= 1'b0;
      tx_idle_pct = (p / 3 == 0) ? 17 : (p / 3 == 1) ? 61 : 0;
      rx_idle_pct = (p / 3 == 0) ? 61 : (p / 3 == 1) ? 17 : 0;
      while (bytes_sent < DIRECTED_ROWS + (p + 1) * BYTES_PER_PHASE) send_random_bitmap();
    end

    byte_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("tb: %0d stream bytes over %0d image sizes, three idle patterns", bytes_sent,
             PHASES);
    $display("tb: checked %0d run descriptors, %0d completions, %0d errors; %0d mismatches",
             runs_checked, done_checked, err_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/rrld_pkg.sv
sv/rrld_core.sv
sv/rrld_out_fifo.sv
sv/residual_run_length_decoder.sv
tb/sv/residual_run_length_decoder_test.sv
